// ----- design/exact_multiplicity_filter_core_assert.svh -----
// assertion macros used by the filter sequencer emf_seq
// each macro expects i_clk and i_rst_n in the enclosing module
`ifndef EXACT_MULTIPLICITY_FILTER_CORE_ASSERT_SVH
`define EXACT_MULTIPLICITY_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define EMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("emf assertion failed");

// next-cycle implication
`define EMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("emf assertion failed");

`endif

// ----- design/emf_pkg.sv -----
`default_nettype none

package emf_pkg;

    typedef logic signed [31:0] t_word;

    localparam int REPEAT_W = 6;
    typedef logic [REPEAT_W-1:0] t_repeat;
    localparam t_repeat REPEAT_RESET = t_repeat'(2);

    // at most this many result words per set
    localparam int RESULT_LIMIT = 32;
    typedef logic [5:0] t_res_cnt;

    typedef struct packed {
        logic  req;
        t_word value;
        logic  empty;
        logic  ovf;
        logic  last;
    } t_emit;

endpackage

`default_nettype wire

// ----- design/emf_if.sv -----
`default_nettype none

interface emf_in_if;
    logic               valid;
    logic               ready;
    emf_pkg::t_word     value;
    logic               last_in;
    modport source (output valid, output value, output last_in, input ready);
    modport sink (input valid, input value, input last_in, output ready);
endinterface

interface emf_res_if;
    logic               valid;
    logic               ready;
    emf_pkg::t_word     result_value;
    logic               empty_res;
    logic               overflowed;
    logic               last_out;
    modport source (output valid, output result_value, output empty_res,
                    output overflowed, output last_out, input ready);
    modport sink (input valid, input result_value, input empty_res,
                  input overflowed, input last_out, output ready);
endinterface

interface emf_cfg_if;
    logic               valid;
    logic               ready;
    emf_pkg::t_repeat   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/emf_store.sv -----
`default_nettype none

module emf_store #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  emf_pkg::t_word      i_wdata,
    input  wire                 i_re,
    input  wire [AW-1:0]        i_raddr,
    output emf_pkg::t_word      o_rdata
);
    import emf_pkg::*;

    t_word mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/emf_seq.sv -----
`default_nettype none
`include "exact_multiplicity_filter_core_assert.svh"

module emf_seq #(
    parameter int MAX_ITEMS = 32,
    localparam int AW = $clog2(MAX_ITEMS),
    localparam int CW = $clog2(MAX_ITEMS + 1)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  emf_pkg::t_word      i_value,
    input  wire                 i_last_in,
    output logic                o_in_ready,
    input  emf_pkg::t_repeat    i_repeat_count,
    input  wire                 i_out_free,
    output emf_pkg::t_emit      o_emit,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output emf_pkg::t_word      o_mem_wdata,
    output logic                o_mem_re,
    output logic [AW-1:0]       o_mem_raddr,
    input  emf_pkg::t_word      i_mem_rdata
);
    import emf_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_RD   = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CMP = 3'd4;
    localparam logic [2:0] S_SCAN_END = 3'd5;

    localparam logic [CW-1:0] FILL_MAX = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE      = CW'(1);
    localparam logic [CW-1:0] TWO      = CW'(2);

    logic [2:0]     r_state,    n_state;
    logic [CW-1:0]  r_fill,     n_fill;
    logic           r_ovf,      n_ovf;
    t_word          r_val,      n_val;
    logic           r_last,     n_last;
    logic [CW-1:0]  r_pos,      n_pos;
    logic [CW-1:0]  r_idx,      n_idx;
    t_word          r_run_val,  n_run_val;
    logic [CW-1:0]  r_run_cnt,  n_run_cnt;
    logic           r_run_ok,   n_run_ok;
    logic           r_pend_v,   n_pend_v;
    t_word          r_pend_val, n_pend_val;
    t_res_cnt       r_n_emit,   n_n_emit;

    logic           run_hit;
    logic           limit_hit;
    logic           same_run;
    logic [CW-1:0]  pos_m1;
    logic [CW-1:0]  pos_m2;

    assign run_hit   = r_run_ok && (32'(r_run_cnt) == 32'(i_repeat_count));
    assign limit_hit = (r_n_emit == t_res_cnt'(RESULT_LIMIT - 1));
    assign same_run  = r_run_ok && (i_mem_rdata == r_run_val);
    assign pos_m1    = r_pos - ONE;
    assign pos_m2    = r_pos - TWO;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_ovf      = r_ovf;
        n_val      = r_val;
        n_last     = r_last;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_run_val  = r_run_val;
        n_run_cnt  = r_run_cnt;
        n_run_ok   = r_run_ok;
        n_pend_v   = r_pend_v;
        n_pend_val = r_pend_val;
        n_n_emit   = r_n_emit;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = r_val;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        o_emit      = '0;
        o_emit.ovf  = r_ovf;
        o_in_ready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx    = '0;
                    n_run_ok = 1'b0;
                    n_pend_v = 1'b0;
                    n_n_emit = '0;
                    if (r_fill < FILL_MAX) begin
                        n_val   = i_value;
                        n_last  = i_last_in;
                        n_pos   = r_fill;
                        n_state = S_INS_RD;
                    end else begin
                        // store full: word dropped
                        n_ovf = 1'b1;
                        if (i_last_in) begin
                            n_state = S_SCAN_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    o_mem_we = 1'b1;
                    n_fill   = r_fill + ONE;
                    n_state  = r_last ? S_SCAN_RD : S_IDLE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = pos_m1[AW-1:0];
                    n_state     = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos[AW-1:0];
                if (i_mem_rdata > r_val) begin
                    // shift the larger entry up, fetch the next one below if there is one
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = pos_m1;
                    if (r_pos > ONE) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = pos_m2[AW-1:0];
                    end else begin
                        n_state = S_INS_RD;
                    end
                end else begin
                    n_fill  = r_fill + ONE;
                    n_state = r_last ? S_SCAN_RD : S_IDLE;
                end
            end
            S_SCAN_RD: begin
                if (r_idx < r_fill) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx[AW-1:0];
                    n_state     = S_SCAN_CMP;
                end else begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_CMP: begin
                if (same_run) begin
                    n_run_cnt = r_run_cnt + ONE;
                    n_idx     = r_idx + ONE;
                    n_state   = S_SCAN_RD;
                end else if (run_hit && r_pend_v) begin
                    o_emit.req   = 1'b1;
                    o_emit.value = r_pend_val;
                    o_emit.last  = limit_hit;
                    if (i_out_free) begin
                        n_n_emit   = r_n_emit + 6'd1;
                        n_pend_val = r_run_val;
                        if (limit_hit) begin
                            n_fill  = '0;
                            n_ovf   = 1'b0;
                            n_state = S_IDLE;
                        end else begin
                            n_run_val = i_mem_rdata;
                            n_run_cnt = ONE;
                            n_run_ok  = 1'b1;
                            n_idx     = r_idx + ONE;
                            n_state   = S_SCAN_RD;
                        end
                    end
                end else begin
                    if (run_hit) begin
                        n_pend_v   = 1'b1;
                        n_pend_val = r_run_val;
                    end
                    n_run_val = i_mem_rdata;
                    n_run_cnt = ONE;
                    n_run_ok  = 1'b1;
                    n_idx     = r_idx + ONE;
                    n_state   = S_SCAN_RD;
                end
            end
            S_SCAN_END: begin
                if (run_hit) begin
                    if (r_pend_v) begin
                        o_emit.req   = 1'b1;
                        o_emit.value = r_pend_val;
                        o_emit.last  = limit_hit;
                        if (i_out_free) begin
                            n_n_emit   = r_n_emit + 6'd1;
                            n_pend_val = r_run_val;
                            n_run_ok   = 1'b0;
                            if (limit_hit) begin
                                n_fill  = '0;
                                n_ovf   = 1'b0;
                                n_state = S_IDLE;
                            end
                        end
                    end else begin
                        n_pend_v   = 1'b1;
                        n_pend_val = r_run_val;
                        n_run_ok   = 1'b0;
                    end
                end else begin
                    // final word: the held value, or the empty marker
                    o_emit.req   = 1'b1;
                    o_emit.last  = 1'b1;
                    o_emit.value = r_pend_v ? r_pend_val : '0;
                    o_emit.empty = !r_pend_v;
                    if (i_out_free) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_run_ok <= 1'b0;
            r_pend_v <= 1'b0;
            r_n_emit <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovf    <= n_ovf;
            r_run_ok <= n_run_ok;
            r_pend_v <= n_pend_v;
            r_n_emit <= n_n_emit;
        end
        r_val      <= n_val;
        r_last     <= n_last;
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_run_val  <= n_run_val;
        r_run_cnt  <= n_run_cnt;
        r_pend_val <= n_pend_val;
    end

    `EMF_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FILL_MAX)
    `EMF_ASSERT_NOW(a_no_rw_clash, o_mem_we && o_mem_re, o_mem_waddr != o_mem_raddr)
    `EMF_ASSERT_NEXT(a_full_sets_ovf,
        (r_state == S_IDLE) && i_in_valid && (r_fill == FILL_MAX) && !i_last_in, r_ovf)
    `EMF_ASSERT_NEXT(a_last_clears,
        o_emit.req && o_emit.last && i_out_free, (r_state == S_IDLE) && (r_fill == '0))

endmodule

`default_nettype wire

// ----- design/exact_multiplicity_filter_core.sv -----
// exact multiplicity filter
// i_in carries one signed 32-bit value per word, with last_in on the final
// value of a set. values are kept in ascending order in an internal memory
// of MAX_ITEMS entries; values beyond that are dropped and flagged.
// inserting a value shifts each stored entry larger than it up one place
// through the memory, then writes the value into the freed place; a new word
// is only taken once the insertion of the one before is done. after the last
// value, the memory is scanned entry by entry in ascending order and the set
// is closed; o_res then carries each value
// occurring exactly repeat_count times, in ascending order and once each,
// last_out on the final one. with no such value one word with empty_res set
// and result_value zero is sent. overflowed tells whether values of that set
// were dropped. i_in is only ready between insertions and outside the scan.
// o_res is driven from an output register; a stall of the receiver holds the
// scan until the register frees up, nothing is lost.
// i_cfg writes repeat_count (reset 2) and is always ready; write it only
// while the block is idle. reset (i_rst_n low, synchronous) empties the set.
`default_nettype none

module exact_multiplicity_filter_core #(
    parameter int MAX_ITEMS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    emf_in_if.sink      i_in,
    emf_res_if.source   o_res,
    emf_cfg_if.sink     i_cfg
);
    import emf_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);

    t_repeat        r_repeat_count;
    logic           r_out_valid;
    t_word          r_out_value;
    logic           r_out_empty;
    logic           r_out_ovf;
    logic           r_out_last;

    logic           out_free;
    t_emit          emit;
    logic           in_ready;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    t_word          mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    t_word          mem_rdata;

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    emf_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_value        (i_in.value),
        .i_last_in      (i_in.last_in),
        .o_in_ready     (in_ready),
        .i_repeat_count (r_repeat_count),
        .i_out_free     (out_free),
        .o_emit         (emit),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    emf_store #(
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_count <= REPEAT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_repeat_count <= i_cfg.data;
            end
            if (emit.req && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit.req && out_free) begin
            r_out_value <= emit.value;
            r_out_empty <= emit.empty;
            r_out_ovf   <= emit.ovf;
            r_out_last  <= emit.last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_value;
    assign o_res.empty_res    = r_out_empty;
    assign o_res.overflowed   = r_out_ovf;
    assign o_res.last_out     = r_out_last;

endmodule

`default_nettype wire
